FILE: rtl/core/star_cif_tokenizer_unit_macros.svh
// assertion helpers for the tokenizer
`ifndef STAR_CIF_TOKENIZER_UNIT_MACROS_SVH
`define STAR_CIF_TOKENIZER_UNIT_MACROS_SVH

// checked only outside reset
`define SCT_ASSERT_ON(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/sct_pkg.sv
package sct_pkg;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_BARE    = 3'd2,
      MODE_QUOTED  = 3'd3,
      MODE_FIELD   = 3'd4
   } mode_type;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] CHR_HASH   = 8'h23;
   localparam logic [7:0] CHR_SEMI   = 8'h3B;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_SPACE  = 8'h20;

   // result queue
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   typedef struct packed {
      logic       action;
      logic [7:0] text_byte;
   } sct_req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] token_byte;
      logic       quoted;
      logic       last_of_run;
   } sct_rsp_type;

   // results of one byte step, handed to the queue
   typedef struct packed {
      logic [1:0]             count;
      sct_rsp_type [1:0]      beat;
   } sct_push_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CHR_SPACE) || (b == CHR_TAB) || (b == CHR_CR) || (b == CHR_LF);
   endfunction

endpackage

FILE: rtl/core/sct_scan.sv
module sct_scan import sct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sct_req_type  req_data,
   input  logic         space,
   output sct_push_type push
);

   logic        in_valid_ff, in_valid_in;
   sct_req_type in_ff, in_in;

   mode_type mode_ff, mode_in;
   logic     als_ff, als_in;     // at line start
   logic     qd_ff, qd_in;       // quote is double
   logic     qp_ff, qp_in;       // quote pending
   logic     ffb_ff, ffb_in;     // field first byte
   logic     fls_ff, fls_in;     // field line start
   logic     nh_ff, nh_in;       // newline held

   logic       accept, advance;
   logic [7:0] b;
   logic [7:0] qc;
   logic       ws;

   assign advance   = in_valid_ff && space;
   assign req_stall = in_valid_ff && !space;
   assign accept    = req_valid && !req_stall;

   assign b  = in_ff.text_byte;
   assign qc = qd_ff ? CHR_DQUOTE : CHR_SQUOTE;
   assign ws = is_ws(b);

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_in       = req_data;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      als_in  = als_ff;
      qd_in   = qd_ff;
      qp_in   = qp_ff;
      ffb_in  = ffb_ff;
      fls_in  = fls_ff;
      nh_in   = nh_ff;
      if (advance) begin
         if (in_ff.action == ACT_END) begin
            mode_in = MODE_BETWEEN;
            als_in  = 1'b1;
            qd_in   = 1'b0;
            qp_in   = 1'b0;
            ffb_in  = 1'b0;
            fls_in  = 1'b0;
            nh_in   = 1'b0;
         end else begin
            case (mode_ff)
               MODE_COMMENT: begin
                  if (b == CHR_LF) begin
                     mode_in = MODE_BETWEEN;
                     als_in  = 1'b1;
                  end
               end
               MODE_BARE: begin
                  if (ws) begin
                     mode_in = MODE_BETWEEN;
                     als_in  = (b == CHR_LF);
                  end
               end
               MODE_QUOTED: begin
                  if (qp_ff && ws) begin
                     qp_in   = 1'b0;
                     mode_in = MODE_BETWEEN;
                     als_in  = (b == CHR_LF);
                  end else begin
                     qp_in = (b == qc);
                  end
               end
               MODE_FIELD: begin
                  if (nh_ff && b != CHR_SEMI) begin
                     nh_in = 1'b0;
                  end
                  if (fls_ff && b == CHR_SEMI) begin
                     nh_in   = 1'b0;
                     mode_in = MODE_BETWEEN;
                     als_in  = 1'b0;
                  end else begin
                     fls_in = (b == CHR_LF);
                     ffb_in = 1'b0;
                     // leading newline of the field is dropped
                     if (!(ffb_ff && b == CHR_LF) && b == CHR_LF) begin
                        nh_in = 1'b1;
                     end
                  end
               end
               default: begin
                  mode_in = MODE_BETWEEN;
                  if (ws) begin
                     als_in = (b == CHR_LF);
                  end else if (b == CHR_HASH) begin
                     mode_in = MODE_COMMENT;
                  end else if (b == CHR_SEMI && als_ff) begin
                     mode_in = MODE_FIELD;
                     ffb_in  = 1'b1;
                     fls_in  = 1'b0;
                     nh_in   = 1'b0;
                     als_in  = 1'b0;
                  end else if (b == CHR_SQUOTE || b == CHR_DQUOTE) begin
                     mode_in = MODE_QUOTED;
                     qd_in   = (b == CHR_DQUOTE);
                     qp_in   = 1'b0;
                     als_in  = 1'b0;
                  end else begin
                     mode_in = MODE_BARE;
                     als_in  = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   // results of the step
   always_comb begin
      sct_rsp_type [1:0] res;
      logic [1:0]        cnt;
      res = '0;
      cnt = 2'd0;
      if (in_ff.action == ACT_END) begin
         if (mode_ff == MODE_BARE) begin
            res[cnt[0]] = '{kind: KIND_END, token_byte: 8'h00, quoted: 1'b0, last_of_run: 1'b0};
            cnt = cnt + 2'd1;
         end else if (mode_ff == MODE_QUOTED || mode_ff == MODE_FIELD) begin
            res[cnt[0]] = '{kind: KIND_END, token_byte: 8'h00, quoted: 1'b1, last_of_run: 1'b0};
            cnt = cnt + 2'd1;
         end
      end else begin
         case (mode_ff)
            MODE_COMMENT: begin
               cnt = 2'd0;
            end
            MODE_BARE: begin
               if (ws) begin
                  res[cnt[0]] = '{kind: KIND_END, token_byte: 8'h00, quoted: 1'b0,
                                  last_of_run: 1'b0};
               end else begin
                  res[cnt[0]] = '{kind: KIND_BYTE, token_byte: b, quoted: 1'b0,
                                  last_of_run: 1'b0};
               end
               cnt = cnt + 2'd1;
            end
            MODE_QUOTED: begin
               if (qp_ff && ws) begin
                  res[cnt[0]] = '{kind: KIND_END, token_byte: 8'h00, quoted: 1'b1,
                                  last_of_run: 1'b0};
                  cnt = cnt + 2'd1;
               end else begin
                  // held quote turns out to be content
                  if (qp_ff) begin
                     res[cnt[0]] = '{kind: KIND_BYTE, token_byte: qc, quoted: 1'b0,
                                     last_of_run: 1'b0};
                     cnt = cnt + 2'd1;
                  end
                  if (b != qc) begin
                     res[cnt[0]] = '{kind: KIND_BYTE, token_byte: b, quoted: 1'b0,
                                     last_of_run: 1'b0};
                     cnt = cnt + 2'd1;
                  end
               end
            end
            MODE_FIELD: begin
               if (nh_ff && b != CHR_SEMI) begin
                  res[cnt[0]] = '{kind: KIND_BYTE, token_byte: CHR_LF, quoted: 1'b0,
                                  last_of_run: 1'b0};
                  cnt = cnt + 2'd1;
               end
               if (fls_ff && b == CHR_SEMI) begin
                  res[cnt[0]] = '{kind: KIND_END, token_byte: 8'h00, quoted: 1'b1,
                                  last_of_run: 1'b0};
                  cnt = cnt + 2'd1;
               end else if (b != CHR_LF) begin
                  res[cnt[0]] = '{kind: KIND_BYTE, token_byte: b, quoted: 1'b0,
                                  last_of_run: 1'b0};
                  cnt = cnt + 2'd1;
               end
            end
            default: begin
               if (!ws && b != CHR_HASH && !(b == CHR_SEMI && als_ff) &&
                   b != CHR_SQUOTE && b != CHR_DQUOTE) begin
                  res[cnt[0]] = '{kind: KIND_BYTE, token_byte: b, quoted: 1'b0,
                                  last_of_run: 1'b0};
                  cnt = cnt + 2'd1;
               end
            end
         endcase
      end
      if (cnt == 2'd2) begin
         res[1].last_of_run = 1'b1;
      end else if (cnt == 2'd1) begin
         res[0].last_of_run = 1'b1;
      end
      push.beat  = res;
      push.count = advance ? cnt : 2'd0;
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_BETWEEN;
         als_ff      <= 1'b1;
         qd_ff       <= 1'b0;
         qp_ff       <= 1'b0;
         ffb_ff      <= 1'b0;
         fls_ff      <= 1'b0;
         nh_ff       <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         als_ff      <= als_in;
         qd_ff       <= qd_in;
         qp_ff       <= qp_in;
         ffb_ff      <= ffb_in;
         fls_ff      <= fls_in;
         nh_ff       <= nh_in;
      end
   end

endmodule

FILE: rtl/core/sct_rsp_queue.sv
module sct_rsp_queue import sct_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sct_push_type        push,
   output logic                space,
   output logic [QCNT_W-1:0]   fill,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sct_rsp_type         rsp_data
);

   sct_rsp_type              mem_ff [QDEPTH];
   logic [QPTR_W-1:0]        wptr_ff, wptr_in;
   logic [QPTR_W-1:0]        rptr_ff, rptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic                     pop;
   logic [QPTR_W-1:0]        wptr_next;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for the two beats one byte may cause
   assign space     = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign fill      = count_ff;
   assign wptr_next = wptr_ff + QPTR_W'(1);

   always_comb begin
      wptr_in  = wptr_ff + QPTR_W'(push.count);
      rptr_in  = rptr_ff + QPTR_W'(pop);
      count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wptr_ff] <= push.beat[0];
      end
      if (push.count == 2'd2) begin
         mem_ff[wptr_next] <= push.beat[1];
      end
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/star_cif_tokenizer_unit.sv
// channel   ports                          beat
// --------  -----------------------------  ----------------------------------
// input     req_valid req_stall req_data   action, text_byte
// result    rsp_valid rsp_stall rsp_data   kind, token_byte, quoted, last_of_run
//
// one text byte per cycle unless req_stall holds it: the byte sits in an input register,
// scan logic updates the mode and writes 0..2 result beats into a 4-entry queue
// a byte that yields two beats writes both into the queue at once; they leave on the result side as two beats
// reset (synchronous) empties the queue and returns to between tokens at line start
// req_stall rises only when the queue cannot take two more beats

module star_cif_tokenizer_unit import sct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sct_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sct_rsp_type rsp_data
);

   sct_push_type        push;
   logic                space;
   logic [QCNT_W-1:0]   fill;
   logic                pair_flags_ok;
   logic                single_flag_ok;

   sct_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .space     (space),
      .push      (push)
   );

   sct_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .fill      (fill),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign pair_flags_ok  = !push.beat[0].last_of_run && push.beat[1].last_of_run;
   assign single_flag_ok = push.beat[0].last_of_run;

`include "star_cif_tokenizer_unit_macros.svh"

   `SCT_ASSERT_ON(a_queue_bound, (fill <= QCNT_W'(QDEPTH)), "result queue overflow")
   `SCT_ASSERT_ON(a_pair_last, (push.count == 2'd2) |-> pair_flags_ok, "bad last flag on pair")
   `SCT_ASSERT_ON(a_single_last, (push.count == 2'd1) |-> single_flag_ok, "lone beat not last")
   `SCT_ASSERT_ALWAYS(a_reset_idle, reset |=> (!req_stall && !rsp_valid), "not idle after reset")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sct_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 150;
   localparam int DRAIN_CYCLES  = 16;
   localparam logic TYPED       = 1'b1;
   localparam logic PREDICTED   = 1'b0;
   localparam logic [9:0] NO_BEAT = '0;

   // one input beat plus, for directed rows, the results typed in by hand
   typedef struct packed {
      sct_req_type       req;
      logic              typed;
      logic [1:0]        n;
      sct_rsp_type [1:0] rsp;
   } text_beat_type;

   // r0/r1 hold {kind, token_byte, quoted}; last_of_run is derived from n
   typedef struct packed {
      logic       act;
      logic [7:0] chr;
      logic       typed;
      logic [1:0] n;
      logic [9:0] r0;
      logic [9:0] r1;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sct_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sct_rsp_type rsp_data;

   text_beat_type    text_feed[$];
   text_beat_type    held_beat = '0;
   sct_rsp_type      token_beats_due[$];
   directed_row_type directed_rows [28];

   int fed_count = 0;
   int accepted_count = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   // tokenizer shadow state
   mode_type    tk_mode;
   logic        tk_line_start;
   logic        tk_dq;
   logic        tk_qpend;
   logic        tk_first;
   logic        tk_fline;
   logic        tk_nlheld;
   sct_rsp_type scan_out [2];
   int          scan_n;

   star_cif_tokenizer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic blank(logic [7:0] b);
      return b == CHR_SPACE || b == CHR_TAB || b == CHR_CR || b == CHR_LF;
   endfunction

   // append at the tail of the feed and of the expected results
   function void queue_feed(text_beat_type beat);
      text_feed.insert(text_feed.size(), beat);
   endfunction

   function void expect_beat(sct_rsp_type r);
      token_beats_due.insert(token_beats_due.size(), r);
   endfunction

   function void tokenizer_restart();
      tk_mode       = MODE_BETWEEN;
      tk_line_start = 1'b1;
      tk_dq         = 1'b0;
      tk_qpend      = 1'b0;
      tk_first      = 1'b0;
      tk_fline      = 1'b0;
      tk_nlheld     = 1'b0;
   endfunction

   function void put_beat(logic kind, logic [7:0] b, logic q);
      scan_out[scan_n] = '{kind, b, q, 1'b0};
      scan_n++;
   endfunction

   function void quote_body(logic [7:0] b);
      if (b == (tk_dq ? CHR_DQUOTE : CHR_SQUOTE)) tk_qpend = 1'b1;
      else put_beat(KIND_BYTE, b, 1'b0);
   endfunction

   function void field_body(logic [7:0] b);
      logic drop;
      if (tk_fline && b == CHR_SEMI) begin
         tk_nlheld = 1'b0;
         put_beat(KIND_END, 8'h00, 1'b1);
         tk_mode = MODE_BETWEEN;
         tk_line_start = 1'b0;
      end else begin
         tk_fline = (b == CHR_LF);
         // newline right after the opening semicolon is not content
         drop = tk_first && b == CHR_LF;
         tk_first = 1'b0;
         if (!drop) begin
            if (b == CHR_LF) tk_nlheld = 1'b1;
            else put_beat(KIND_BYTE, b, 1'b0);
         end
      end
   endfunction

   // advances the shadow state by one beat, leaves results in scan_out
   function void scan_byte(sct_req_type r);
      logic [7:0] b;
      b = r.text_byte;
      scan_n = 0;
      if (r.action == ACT_END) begin
         if (tk_mode == MODE_BARE) put_beat(KIND_END, 8'h00, 1'b0);
         else if (tk_mode == MODE_QUOTED || tk_mode == MODE_FIELD)
            put_beat(KIND_END, 8'h00, 1'b1);
         tokenizer_restart();
      end else begin
         case (tk_mode)
            MODE_COMMENT: begin
               if (b == CHR_LF) begin
                  tk_mode = MODE_BETWEEN;
                  tk_line_start = 1'b1;
               end
            end
            MODE_BARE: begin
               if (blank(b)) begin
                  put_beat(KIND_END, 8'h00, 1'b0);
                  tk_mode = MODE_BETWEEN;
                  tk_line_start = (b == CHR_LF);
               end else begin
                  put_beat(KIND_BYTE, b, 1'b0);
               end
            end
            MODE_QUOTED: begin
               if (tk_qpend) begin
                  tk_qpend = 1'b0;
                  if (blank(b)) begin
                     put_beat(KIND_END, 8'h00, 1'b1);
                     tk_mode = MODE_BETWEEN;
                     tk_line_start = (b == CHR_LF);
                  end else begin
                     put_beat(KIND_BYTE, tk_dq ? CHR_DQUOTE : CHR_SQUOTE, 1'b0);
                     quote_body(b);
                  end
               end else begin
                  quote_body(b);
               end
            end
            MODE_FIELD: begin
               if (tk_nlheld && b != CHR_SEMI) begin
                  tk_nlheld = 1'b0;
                  put_beat(KIND_BYTE, CHR_LF, 1'b0);
               end
               field_body(b);
            end
            default: begin
               tk_mode = MODE_BETWEEN;
               if (blank(b)) begin
                  tk_line_start = (b == CHR_LF);
               end else if (b == CHR_HASH) begin
                  tk_mode = MODE_COMMENT;
               end else if (b == CHR_SEMI && tk_line_start) begin
                  tk_mode = MODE_FIELD;
                  tk_first = 1'b1;
                  tk_fline = 1'b0;
                  tk_nlheld = 1'b0;
                  tk_line_start = 1'b0;
               end else if (b == CHR_SQUOTE || b == CHR_DQUOTE) begin
                  tk_mode = MODE_QUOTED;
                  tk_dq = (b == CHR_DQUOTE);
                  tk_qpend = 1'b0;
                  tk_line_start = 1'b0;
               end else begin
                  tk_mode = MODE_BARE;
                  tk_line_start = 1'b0;
                  put_beat(KIND_BYTE, b, 1'b0);
               end
            end
         endcase
      end
      if (scan_n > 0) scan_out[scan_n - 1].last_of_run = 1'b1;
   endfunction

   function void report_mismatch(string what, sct_rsp_type want, sct_rsp_type got);
      if (fail_count < 10)
         $display("%0t %s: expected kind %0b byte %02h quoted %0b last %0b,",
                  $time, what, want.kind, want.token_byte, want.quoted, want.last_of_run,
                  " got kind %0b byte %02h quoted %0b last %0b",
                  got.kind, got.token_byte, got.quoted, got.last_of_run);
      fail_count++;
   endfunction

   // stimulus helpers
   function void feed_item(logic act, logic [7:0] b);
      text_beat_type beat;
      beat = '0;
      beat.req.action = act;
      beat.req.text_byte = b;
      queue_feed(beat);
      fed_count++;
   endfunction

   function logic [7:0] word_char();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   function logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return CHR_SPACE;
         1: return CHR_TAB;
         2: return CHR_CR;
         default: return CHR_LF;
      endcase
   endfunction

   function void add_text_fragment();
      int pick;
      int len;
      int lines;
      logic [7:0] q;
      logic [7:0] c;
      logic fresh;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         // bare word
         len = $urandom_range(0, 6);
         for (int k = 0; k <= len; k++) begin
            c = word_char();
            if (blank(c)) c = "_";
            feed_item(ACT_BYTE, c);
         end
         if ($urandom_range(0, 9) == 0) feed_item(ACT_END, 8'($urandom_range(0, 255)));
         else feed_item(ACT_BYTE, blank_char());
      end else if (pick < 45) begin
         // quoted string, with embedded quotes and the other quote char
         q = $urandom_range(0, 1) ? CHR_DQUOTE : CHR_SQUOTE;
         feed_item(ACT_BYTE, q);
         len = $urandom_range(0, 7);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 5))
               0: begin
                  feed_item(ACT_BYTE, q);
                  c = word_char();
                  if (blank(c)) c = "y";
                  feed_item(ACT_BYTE, c);
               end
               1: feed_item(ACT_BYTE, (q == CHR_DQUOTE) ? CHR_SQUOTE : CHR_DQUOTE);
               2: feed_item(ACT_BYTE, blank_char());
               default: feed_item(ACT_BYTE, word_char());
            endcase
         end
         case ($urandom_range(0, 9))
            0: feed_item(ACT_END, 8'($urandom_range(0, 255)));
            1: begin
               feed_item(ACT_BYTE, q);
               feed_item(ACT_END, 8'($urandom_range(0, 255)));
            end
            default: begin
               feed_item(ACT_BYTE, q);
               feed_item(ACT_BYTE, blank_char());
            end
         endcase
      end else if (pick < 55) begin
         feed_item(ACT_BYTE, CHR_HASH);
         len = $urandom_range(0, 6);
         for (int k = 0; k < len; k++) feed_item(ACT_BYTE, 8'($urandom_range(0, 255)));
         feed_item(ACT_BYTE, CHR_LF);
      end else if (pick < 70) begin
         // text field: semicolon at line start, lines, closing semicolon or end of text
         feed_item(ACT_BYTE, CHR_LF);
         feed_item(ACT_BYTE, CHR_SEMI);
         fresh = 1'b0;
         if ($urandom_range(0, 3) != 0) begin
            feed_item(ACT_BYTE, CHR_LF);
            fresh = 1'b1;
         end
         lines = $urandom_range(0, 3);
         for (int l = 0; l < lines; l++) begin
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++) begin
               c = ($urandom_range(0, 5) == 0) ? blank_char() : word_char();
               if (fresh && c == CHR_SEMI) c = "x";
               feed_item(ACT_BYTE, c);
               fresh = (c == CHR_LF);
            end
            feed_item(ACT_BYTE, CHR_LF);
            fresh = 1'b1;
         end
         if ($urandom_range(0, 7) == 0) begin
            feed_item(ACT_END, 8'($urandom_range(0, 255)));
         end else begin
            if (!fresh) feed_item(ACT_BYTE, CHR_LF);
            feed_item(ACT_BYTE, CHR_SEMI);
            feed_item(ACT_BYTE, blank_char());
         end
      end else if (pick < 85) begin
         len = $urandom_range(1, 3);
         for (int k = 0; k < len; k++) feed_item(ACT_BYTE, blank_char());
      end else if (pick < 92) begin
         feed_item(ACT_END, 8'($urandom_range(0, 255)));
      end else begin
         len = $urandom_range(1, 4);
         for (int k = 0; k < len; k++) feed_item(ACT_BYTE, 8'($urandom_range(0, 255)));
      end
   endfunction

   // drive beats, predict on acceptance, check results
   always @(posedge clock) begin : bench_step
      text_beat_type next_beat;
      sct_rsp_type   want;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
         tokenizer_restart();
         token_beats_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            scan_byte(req_data);
            accepted_count++;
            if (held_beat.typed) begin
               for (int i = 0; i < held_beat.n; i++) expect_beat(held_beat.rsp[i]);
            end else begin
               for (int i = 0; i < scan_n; i++) expect_beat(scan_out[i]);
            end
         end
         if (!req_valid || !req_stall) begin
            if (text_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_beat = text_feed.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_beat.req;
               held_beat <= next_beat;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (token_beats_due.size() == 0) begin
               report_mismatch("result beat with nothing expected", '0, rsp_data);
            end else begin
               want = token_beats_due.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.token_byte !== want.token_byte ||
                   rsp_data.quoted !== want.quoted ||
                   rsp_data.last_of_run !== want.last_of_run)
                  report_mismatch("result beat mismatch", want, rsp_data);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      text_beat_type beat;
      int idle_plan [4];
      int stall_plan [4];
      idle_plan  = '{0, 71, 0, 10};
      stall_plan = '{0, 0, 71, 10};
      directed_rows = '{
         '{ACT_BYTE, 8'h00,      TYPED, 2'd1, {KIND_BYTE, 8'h00, 1'b0}, NO_BEAT},
         '{ACT_BYTE, 8'hFF,      TYPED, 2'd1, {KIND_BYTE, 8'hFF, 1'b0}, NO_BEAT},
         '{ACT_BYTE, CHR_SPACE,  TYPED, 2'd1, {KIND_END, 8'h00, 1'b0}, NO_BEAT},
         // end of text between tokens
         '{ACT_END,  8'hFF,      TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_DQUOTE, TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_SQUOTE, TYPED, 2'd1, {KIND_BYTE, CHR_SQUOTE, 1'b0}, NO_BEAT},
         '{ACT_BYTE, CHR_DQUOTE, TYPED, 2'd0, NO_BEAT, NO_BEAT},
         // held quote followed by a non-blank turns into content
         '{ACT_BYTE, "x",        TYPED, 2'd2, {KIND_BYTE, CHR_DQUOTE, 1'b0},
           {KIND_BYTE, 8'h78, 1'b0}},
         '{ACT_BYTE, CHR_DQUOTE, TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_TAB,    TYPED, 2'd1, {KIND_END, 8'h00, 1'b1}, NO_BEAT},
         '{ACT_BYTE, CHR_LF,     TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_SEMI,   TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_LF,     TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, "k",        PREDICTED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_LF,     PREDICTED, 2'd0, NO_BEAT, NO_BEAT},
         // held newline released ahead of the next field byte
         '{ACT_BYTE, "m",        PREDICTED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_LF,     PREDICTED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_SEMI,   TYPED, 2'd1, {KIND_END, 8'h00, 1'b1}, NO_BEAT},
         '{ACT_BYTE, CHR_HASH,   TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_END,  8'h00,      TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, "z",        PREDICTED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_END,  8'h00,      TYPED, 2'd1, {KIND_END, 8'h00, 1'b0}, NO_BEAT},
         '{ACT_BYTE, CHR_SQUOTE, TYPED, 2'd0, NO_BEAT, NO_BEAT},
         // unterminated quote still closes its token
         '{ACT_END,  8'h00,      TYPED, 2'd1, {KIND_END, 8'h00, 1'b1}, NO_BEAT},
         '{ACT_BYTE, CHR_SEMI,   TYPED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, "q",        PREDICTED, 2'd0, NO_BEAT, NO_BEAT},
         '{ACT_BYTE, CHR_LF,     PREDICTED, 2'd0, NO_BEAT, NO_BEAT},
         // end inside a field drops the held newline
         '{ACT_END,  8'h00,      TYPED, 2'd1, {KIND_END, 8'h00, 1'b1}, NO_BEAT}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         beat = '0;
         beat.req   = '{directed_rows[i].act, directed_rows[i].chr};
         beat.typed = directed_rows[i].typed;
         beat.n     = directed_rows[i].n;
         beat.rsp[0] = {directed_rows[i].r0, directed_rows[i].n == 2'd1};
         beat.rsp[1] = {directed_rows[i].r1, 1'b1};
         queue_feed(beat);
         fed_count++;
      end
      while (accepted_count != fed_count) @(posedge clock);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct     = stall_plan[p];
         begin : fill_phase
            int target;
            target = fed_count + PHASE_ITEMS;
            while (fed_count < target) add_text_fragment();
         end
         while (accepted_count != fed_count) @(posedge clock);
      end

      send_idle_pct = 0;
      stall_pct = 0;
      while (accepted_count != fed_count || token_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && token_beats_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
